### rtl/dsa_pkg.sv
// ----------------------------------------------------------------------------
// dsa_pkg
// shared types and constants of the descriptor slot allocator
// ----------------------------------------------------------------------------
package dsa_pkg;

   localparam int SLOT_COUNT = 1024;
   localparam int SLOT_W     = $clog2(SLOT_COUNT);
   localparam int CNT_W      = SLOT_W + 1;
   localparam int WORD_W     = 32;

   localparam logic [1:0] ACT_ALLOC  = 2'd0;
   localparam logic [1:0] ACT_FREE   = 2'd1;
   localparam logic [1:0] ACT_REBIND = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_PROTECTED = 2'd2;
   localparam logic [1:0] ST_INVALID   = 2'd3;

   localparam logic [SLOT_W-1:0] LAST_PROTECTED = SLOT_W'(2);

   typedef struct packed {
      logic [1:0]        action;
      logic [SLOT_W-1:0] slot_index;
      logic [WORD_W-1:0] descriptor_word;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0] result_slot;
      logic              write_enable;
      logic [WORD_W-1:0] write_word;
      logic [1:0]        status;
   } rsp_type;

endpackage

### rtl/dsa_ram.sv
// ----------------------------------------------------------------------------
// dsa_ram
// one write port, one registered read port, write data forwarded on collision
// ----------------------------------------------------------------------------
module dsa_ram #(
   parameter int DATA_W = 1,
   parameter int DEPTH  = 4,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;
   logic [DATA_W-1:0] fwd_data_ff;
   logic              fwd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff  <= mem[rd_addr];
      fwd_data_ff <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else begin
         fwd_ff <= wr_en && (wr_addr == rd_addr);
      end
   end

   assign rd_data = fwd_ff ? fwd_data_ff : rd_data_ff;

endmodule

### rtl/descriptor_slot_allocator.sv
// ----------------------------------------------------------------------------
// descriptor_slot_allocator
// slot table manager with a fifo free list and a high-water mark
// ----------------------------------------------------------------------------
// One item is accepted per clock cycle; busy is always low. Each item gives
// exactly one result. The result is registered at the clock edge after the
// edge that accepted the item. It is shown on rsp_data with rsp_valid for the
// cycle that follows. The receiver cannot stall and results come out in
// order. The valid bitmap and the free queue are each one memory with a
// single registered read. Each is read at the edge of acceptance with
// forwarding from the item in flight, so the state update is a single pass.
// No clearing pass runs after reset: the high-water mark bounds bitmap reads.
// ----------------------------------------------------------------------------
module descriptor_slot_allocator
   import dsa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  req_type           req_data,
   output logic              rsp_valid,
   output rsp_type           rsp_data,
   input  logic              csr_we,
   input  logic [WORD_W-1:0] csr_wdata
);

   logic [WORD_W-1:0] dflt_ff;
   logic              s1_valid_ff;
   req_type           s1_item_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;
   rsp_type           rsp_data_in;

   logic [CNT_W-1:0]  hw_ff, hw_in;
   logic [SLOT_W-1:0] head_ff, head_in;
   logic [SLOT_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   logic              vld_we;
   logic [SLOT_W-1:0] vld_waddr;
   logic              vld_wdata;
   logic              vld_rdata;
   logic              q_we;
   logic [SLOT_W-1:0] q_rdata;
   logic              live;

   function automatic logic [SLOT_W-1:0] ptr_next(input logic [SLOT_W-1:0] p);
      if (p == SLOT_W'(SLOT_COUNT - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   assign busy = 1'b0;

   dsa_ram #(.DATA_W(1), .DEPTH(SLOT_COUNT)) u_valid (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (vld_we),
      .wr_addr (vld_waddr),
      .wr_data (vld_wdata),
      .rd_addr (req_data.slot_index),
      .rd_data (vld_rdata)
   );

   dsa_ram #(.DATA_W(SLOT_W), .DEPTH(SLOT_COUNT)) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_we),
      .wr_addr (tail_ff),
      .wr_data (s1_item_ff.slot_index),
      .rd_addr (head_in),
      .rd_data (q_rdata)
   );

   assign live = ({1'b0, s1_item_ff.slot_index} < hw_ff) && vld_rdata;

   always_comb begin
      hw_in       = hw_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      vld_we      = 1'b0;
      vld_waddr   = s1_item_ff.slot_index;
      vld_wdata   = 1'b0;
      q_we        = 1'b0;
      rsp_data_in = '{result_slot: s1_item_ff.slot_index, write_enable: 1'b0,
                      write_word: '0, status: ST_OK};
      if (s1_valid_ff) begin
         unique case (s1_item_ff.action)
            ACT_ALLOC: begin
               if (count_ff != '0) begin
                  vld_waddr = q_rdata;
                  head_in   = ptr_next(head_ff);
                  count_in  = count_ff - 1'b1;
                  vld_we    = 1'b1;
               end else if (hw_ff < CNT_W'(SLOT_COUNT)) begin
                  vld_waddr = hw_ff[SLOT_W-1:0];
                  hw_in     = hw_ff + 1'b1;
                  vld_we    = 1'b1;
               end
               vld_wdata = 1'b1;
               if (vld_we) begin
                  rsp_data_in.result_slot  = vld_waddr;
                  rsp_data_in.write_enable = 1'b1;
                  rsp_data_in.write_word   = s1_item_ff.descriptor_word;
               end else begin
                  rsp_data_in.result_slot = '0;
                  rsp_data_in.status      = ST_FULL;
               end
            end
            ACT_FREE: begin
               if (s1_item_ff.slot_index <= LAST_PROTECTED) begin
                  rsp_data_in.status = ST_PROTECTED;
               end else if (!live || count_ff >= CNT_W'(SLOT_COUNT)) begin
                  rsp_data_in.status = ST_INVALID;
               end else begin
                  vld_we                   = 1'b1;
                  q_we                     = 1'b1;
                  tail_in                  = ptr_next(tail_ff);
                  count_in                 = count_ff + 1'b1;
                  rsp_data_in.write_enable = 1'b1;
                  rsp_data_in.write_word   = dflt_ff;
               end
            end
            ACT_REBIND: begin
               if (live) begin
                  rsp_data_in.write_enable = 1'b1;
                  rsp_data_in.write_word   = s1_item_ff.descriptor_word;
               end else begin
                  rsp_data_in.status = ST_INVALID;
               end
            end
            default: begin
               rsp_data_in.result_slot = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dflt_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         hw_ff        <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
      end else begin
         if (csr_we) begin
            dflt_ff <= csr_wdata;
         end
         s1_valid_ff  <= start && !busy;
         rsp_valid_ff <= s1_valid_ff;
         hw_ff        <= hw_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff  <= req_data;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### rtl/dsa_checker.sv
// ----------------------------------------------------------------------------
// dsa_checker
// port-level checks of the descriptor slot allocator
// ----------------------------------------------------------------------------
module dsa_checker
   import dsa_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   // every accepted item gives one result
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_valid)
      else $error("no result for accepted item");

   a_rsp_caused: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("result without accepted item");

   a_write_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.write_enable) |-> (rsp_data.status == ST_OK))
      else $error("write issued with error status");

   a_err_no_write: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_OK)
         |-> (!rsp_data.write_enable && rsp_data.write_word == '0))
      else $error("error result carries a write");

   a_full_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_FULL) |-> (rsp_data.result_slot == '0))
      else $error("full result names a slot");

endmodule

bind descriptor_slot_allocator dsa_checker u_dsa_checker (.*);

### tb/tb_descriptor_slot_allocator.sv
// ----------------------------------------------------------------------------
// tb_descriptor_slot_allocator
// self-checking regression of the descriptor slot allocator
// ----------------------------------------------------------------------------
// A behavioral copy of the slot table predicts the response of every item that
// is accepted: the valid bitmap, the high-water mark, the fifo of freed slots
// and the default descriptor. A checker compares each response, field by
// field, against the oldest prediction. Directed items cover the protected
// slots, bad indexes, the unused action and free-list reuse order. Random
// traffic then runs a mixed phase, an allocate-heavy phase that fills the
// table until it reports full, and a free-heavy phase. The default descriptor
// is rewritten between phases, including both extremes.
// ----------------------------------------------------------------------------
module tb_descriptor_slot_allocator;
   import dsa_pkg::*;

   localparam int          CLK_PERIOD   = 12;
   localparam int          RUN_LIMIT    = CLK_PERIOD * 250000;
   localparam int          TAIL_CYCLES  = 8;
   localparam int          MAX_PRINTED  = 40;
   localparam logic [1:0]  ACT_UNUSED   = 2'd3;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              start     = 1'b0;
   logic              busy;
   req_type           req_data  = '0;
   logic              rsp_valid;
   rsp_type           rsp_data;
   logic              csr_we    = 1'b0;
   logic [WORD_W-1:0] csr_wdata = '0;

   // model of the slot table
   bit                slot_valid [SLOT_COUNT];
   int                high_water;
   logic [SLOT_W-1:0] freed_slots[$];
   logic [WORD_W-1:0] default_word;

   rsp_type           pending_results[$];
   rsp_type           want_rsp;
   int                error_count;
   int                table_full_hits;
   int                burst_left;

   descriptor_slot_allocator u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #(RUN_LIMIT);
      $display("descriptor_slot_allocator regression: fail");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= MAX_PRINTED)
         $display("%0t mismatch: %s", $time, msg);
   endtask

   function automatic bit slot_is_live(input logic [SLOT_W-1:0] idx);
      return (int'(idx) < high_water) && slot_valid[idx];
   endfunction

   function automatic rsp_type predict_slot_result(input req_type r);
      rsp_type           e;
      logic [SLOT_W-1:0] s;
      e = '0;
      case (r.action)
         ACT_ALLOC: begin
            if (freed_slots.size() > 0) begin
               s = freed_slots.pop_front();
            end else if (high_water < SLOT_COUNT) begin
               s = SLOT_W'(high_water);
               high_water++;
            end else begin
               e.status = ST_FULL;
               return e;
            end
            slot_valid[s]  = 1'b1;
            e.result_slot  = s;
            e.write_enable = 1'b1;
            e.write_word   = r.descriptor_word;
            e.status       = ST_OK;
         end
         ACT_FREE: begin
            e.result_slot = r.slot_index;
            if (r.slot_index <= LAST_PROTECTED) begin
               e.status = ST_PROTECTED;
            end else if (!slot_is_live(r.slot_index) || freed_slots.size() >= SLOT_COUNT) begin
               e.status = ST_INVALID;
            end else begin
               slot_valid[r.slot_index] = 1'b0;
               freed_slots.push_back(r.slot_index);
               e.write_enable = 1'b1;
               e.write_word   = default_word;
               e.status       = ST_OK;
            end
         end
         ACT_REBIND: begin
            e.result_slot = r.slot_index;
            if (!slot_is_live(r.slot_index)) begin
               e.status = ST_INVALID;
            end else begin
               e.write_enable = 1'b1;
               e.write_word   = r.descriptor_word;
               e.status       = ST_OK;
            end
         end
         default: e = '0;
      endcase
      return e;
   endfunction

   // compare each response with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            report_mismatch("response with no item outstanding");
         end else begin
            want_rsp = pending_results.pop_front();
            if (rsp_data.result_slot !== want_rsp.result_slot)
               report_mismatch($sformatf("result_slot %0d, want %0d",
                  rsp_data.result_slot, want_rsp.result_slot));
            if (rsp_data.write_enable !== want_rsp.write_enable)
               report_mismatch($sformatf("write_enable %b, want %b",
                  rsp_data.write_enable, want_rsp.write_enable));
            if (rsp_data.write_word !== want_rsp.write_word)
               report_mismatch($sformatf("write_word %h, want %h",
                  rsp_data.write_word, want_rsp.write_word));
            if (rsp_data.status !== want_rsp.status)
               report_mismatch($sformatf("status %0d, want %0d",
                  rsp_data.status, want_rsp.status));
         end
      end
   end

   function automatic req_type make_req(input logic [1:0] act, input int idx,
                                        input logic [WORD_W-1:0] word);
      req_type r;
      r.action          = act;
      r.slot_index      = SLOT_W'(idx);
      r.descriptor_word = word;
      return r;
   endfunction

   task automatic send_item(input req_type r);
      rsp_type e;
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      e = predict_slot_result(r);
      if (e.status == ST_FULL)
         table_full_hits++;
      pending_results.push_back(e);
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (pending_results.size() > 0)
         @(posedge clock);
   endtask

   task automatic write_default(input logic [WORD_W-1:0] word);
      wait_idle();
      csr_we    <= 1'b1;
      csr_wdata <= word;
      @(posedge clock);
      csr_we       <= 1'b0;
      default_word  = word;
   endtask

   // bursts of back-to-back items with random gaps between them
   task automatic pace_sender();
      if (burst_left == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
   endtask

   function automatic int pick_live_slot();
      int c;
      c = $urandom_range(0, SLOT_COUNT - 1);
      if (high_water == 0)
         return c;
      repeat (32) begin
         c = $urandom_range(0, high_water - 1);
         if (slot_valid[c])
            return c;
      end
      return c;
   endfunction

   function automatic req_type make_random_req(input int alloc_pct, input int free_pct,
                                               input int rebind_pct);
      int         p;
      int         idx;
      logic [1:0] act;
      p = $urandom_range(0, 99);
      if (p < alloc_pct)
         act = ACT_ALLOC;
      else if (p < alloc_pct + free_pct)
         act = ACT_FREE;
      else if (p < alloc_pct + free_pct + rebind_pct)
         act = ACT_REBIND;
      else
         act = ACT_UNUSED;
      idx = $urandom_range(0, SLOT_COUNT - 1);
      if ((act == ACT_FREE || act == ACT_REBIND) && $urandom_range(0, 3) != 0)
         idx = pick_live_slot();
      else if ($urandom_range(0, 15) == 0)
         idx = $urandom_range(0, 2);
      return make_req(act, idx, $urandom);
   endfunction

   task automatic test_directed_cases();
      send_item(make_req(ACT_FREE, 0, 32'hFFFF_FFFF));
      send_item(make_req(ACT_FREE, 2, 32'h0));
      send_item(make_req(ACT_FREE, 3, 32'h1234_5678));
      send_item(make_req(ACT_REBIND, 0, 32'hFFFF_FFFF));
      send_item(make_req(ACT_UNUSED, SLOT_COUNT - 1, 32'hFFFF_FFFF));
      send_item(make_req(ACT_ALLOC, SLOT_COUNT - 1, 32'h0));
      send_item(make_req(ACT_ALLOC, 0, 32'hFFFF_FFFF));
      send_item(make_req(ACT_ALLOC, 0, $urandom));
      send_item(make_req(ACT_ALLOC, 0, $urandom));
      send_item(make_req(ACT_REBIND, 0, 32'hDEAD_BEEF));
      send_item(make_req(ACT_REBIND, SLOT_COUNT - 1, 32'hFFFF_FFFF));
      send_item(make_req(ACT_FREE, SLOT_COUNT - 1, 32'h0));
      send_item(make_req(ACT_FREE, 3, 32'h0));
      write_default(32'h8000_0001);
      send_item(make_req(ACT_ALLOC, 0, 32'h0000_0001));
      send_item(make_req(ACT_ALLOC, 0, 32'h0000_0002));
      send_item(make_req(ACT_FREE, 3, 32'h0));
      send_item(make_req(ACT_FREE, 3, 32'h0));
      send_item(make_req(ACT_REBIND, 3, 32'h5555_5555));
      send_item(make_req(ACT_FREE, 5, 32'h0));
      send_item(make_req(ACT_FREE, 1, 32'h0));
      send_item(make_req(ACT_ALLOC, 0, 32'hAAAA_AAAA));
      send_item(make_req(ACT_ALLOC, 0, 32'h5555_5555));
      send_item(make_req(ACT_ALLOC, 0, 32'h0F0F_0F0F));
   endtask

   task automatic test_mixed_traffic();
      write_default(32'hFFFF_FFFF);
      repeat (200) begin
         pace_sender();
         send_item(make_random_req(45, 30, 20));
      end
   endtask

   task automatic test_fill_to_full();
      int n;
      write_default($urandom);
      n = 0;
      while (table_full_hits < 30 && n < 1400) begin
         pace_sender();
         send_item(make_random_req(92, 3, 3));
         n++;
      end
   endtask

   task automatic test_churn_after_full();
      write_default(32'h0000_0000);
      repeat (200) begin
         pace_sender();
         send_item(make_random_req(35, 45, 15));
      end
   endtask

   initial begin
      slot_valid      = '{default: 1'b0};
      high_water      = 0;
      default_word    = '0;
      error_count     = 0;
      table_full_hits = 0;
      burst_left      = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_mixed_traffic();
      test_fill_to_full();
      test_churn_after_full();

      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_results.size() > 0)
         report_mismatch($sformatf("%0d responses never arrived", pending_results.size()));
      if (error_count == 0)
         $display("descriptor_slot_allocator regression: pass");
      else
         $display("descriptor_slot_allocator regression: fail");
      $finish;
   end

endmodule
